/* hdl/ppc_pkg.sv */
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, constants and register indexes for the polarity calibrator.
// ----------------------------------------------------------------------------
package ppc_pkg;

    typedef logic signed [31:0] sample_t;
    typedef logic [15:0]        thresh_t;
    typedef logic [16:0]        ratio_t;
    typedef logic [1:0]         reg_index_t;
    typedef logic [16:0]        reg_data_t;

    localparam int WINDOW_LEN_DEF = 16;

    // -10000.0 in Q16.16, start value of the window maximum
    localparam sample_t MAX_SEED = -32'sd655360000;

    localparam sample_t SAMPLE_MIN = 32'sh8000_0000;
    localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;

    localparam thresh_t TRIGGER_THRESHOLD_RST = 16'd66;
    localparam thresh_t RISE_THRESHOLD_RST    = 16'd7;
    localparam ratio_t  FALL_RATIO_RST        = 17'd45875;

    localparam reg_index_t REG_TRIGGER_THRESHOLD = 2'd0;
    localparam reg_index_t REG_RISE_THRESHOLD    = 2'd1;
    localparam reg_index_t REG_FALL_RATIO        = 2'd2;

    // window chain control
    typedef struct packed {
        logic shift;
        logic load_tail;
    } ppc_win_ctrl_t;

    // calibration unit control
    typedef struct packed {
        logic mul_en;
        logic upd_en;
    } ppc_cal_ctrl_t;

endpackage

/* hdl/ppc_if.sv */
// ----------------------------------------------------------------------------
// ppc_if
// Valid/ready channel interfaces: sample input, result output, configuration.
// ----------------------------------------------------------------------------
interface ppc_in_if;
    logic             valid;
    logic             ready;
    ppc_pkg::sample_t ref_sample;
    ppc_pkg::sample_t phase_sample;

    modport source (output valid, output ref_sample, output phase_sample, input ready);
    modport sink   (input valid, input ref_sample, input phase_sample, output ready);
endinterface

interface ppc_out_if;
    logic             valid;
    logic             ready;
    ppc_pkg::sample_t corrected_phase;
    logic             polarity_negative;
    ppc_pkg::sample_t held_value;
    ppc_pkg::sample_t local_max;

    modport source (output valid, output corrected_phase, output polarity_negative,
                    output held_value, output local_max, input ready);
    modport sink   (input valid, input corrected_phase, input polarity_negative,
                    input held_value, input local_max, output ready);
endinterface

interface ppc_cfg_if;
    logic                  valid;
    logic                  ready;
    ppc_pkg::reg_index_t   index;
    ppc_pkg::reg_data_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/ppc_cell.sv */
// ----------------------------------------------------------------------------
// ppc_cell
// One window cell: holds a sample and takes its neighbor's value when shifted.
// ----------------------------------------------------------------------------
module ppc_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  ppc_pkg::sample_t din,
    output ppc_pkg::sample_t dout
);
    import ppc_pkg::*;

    sample_t value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

/* hdl/ppc_window.sv */
// ----------------------------------------------------------------------------
// ppc_window
// Ring of window cells; rotates toward the head, tail input can take a new sample.
// ----------------------------------------------------------------------------
module ppc_window #(
    parameter int WINDOW_LEN = ppc_pkg::WINDOW_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppc_pkg::ppc_win_ctrl_t ctrl,
    input  ppc_pkg::sample_t      new_sample,
    output ppc_pkg::sample_t      head,
    output ppc_pkg::sample_t      mid,
    output ppc_pkg::sample_t      tail
);
    import ppc_pkg::*;

    sample_t cell_q [WINDOW_LEN];
    sample_t cell_d [WINDOW_LEN];

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_LEN; gi++)
        begin : g_cell
            if (gi == WINDOW_LEN - 1)
            begin : g_tail
                // wrap-around unless a new sample enters
                assign cell_d[gi] = ctrl.load_tail ? new_sample : cell_q[0];
            end
            else
            begin : g_body
                assign cell_d[gi] = cell_q[gi + 1];
            end

            ppc_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (ctrl.shift),
                .din   (cell_d[gi]),
                .dout  (cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[0];
    assign mid  = cell_q[WINDOW_LEN / 2];
    assign tail = cell_q[WINDOW_LEN - 1];

endmodule

/* hdl/ppc_calib.sv */
// ----------------------------------------------------------------------------
// ppc_calib
// Descent product, trigger/descend/in-window flags and polarity correction.
// ----------------------------------------------------------------------------
module ppc_calib (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ppc_pkg::ppc_cal_ctrl_t ctrl,
    input  ppc_pkg::thresh_t       trigger_threshold,
    input  ppc_pkg::thresh_t       rise_threshold,
    input  ppc_pkg::ratio_t        fall_ratio,
    input  ppc_pkg::sample_t       ref_sample,
    input  ppc_pkg::sample_t       phase_sample,
    input  ppc_pkg::sample_t       held_ref,
    input  ppc_pkg::sample_t       peak_value,
    output ppc_pkg::sample_t       corrected_phase,
    output logic                   polarity_negative
);
    import ppc_pkg::*;

    logic signed [49:0] prod_reg;
    logic               trigger_reg;
    logic               descend_reg;
    logic               in_window_reg;
    sample_t            last_phase_reg;

    logic               trigger_next;
    logic               descend_next;
    logic               in_window_next;

    logic               trig_clr;
    logic               arm;
    logic               desc_arm;
    logic signed [32:0] diff;
    logic        [32:0] abs_dev;
    logic signed [33:0] scaled;
    logic signed [34:0] desc_sum;
    logic signed [33:0] rise_limit;
    logic               rising;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= 50'(peak_value) * 50'($signed({1'b0, fall_ratio}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg    <= 1'b0;
            descend_reg    <= 1'b0;
            in_window_reg  <= 1'b0;
            last_phase_reg <= '0;
        end
        else if (ctrl.upd_en)
        begin
            trigger_reg    <= trigger_next;
            descend_reg    <= descend_next;
            in_window_reg  <= in_window_next;
            last_phase_reg <= phase_sample;
        end
    end

    always_comb
    begin
        trig_clr = trigger_reg && (ref_sample != held_ref);

        diff    = {ref_sample[31], ref_sample} - {held_ref[31], held_ref};
        abs_dev = diff[32] ? 33'(-diff) : 33'(diff);
        arm     = (abs_dev > {17'b0, trigger_threshold}) && !trig_clr;

        trigger_next   = trig_clr || arm;
        desc_arm       = arm ? 1'b0 : descend_reg;
        in_window_next = arm ? 1'b1 : in_window_reg;

        // floor of product / 2^16
        scaled   = prod_reg[49:16];
        desc_sum = {{3{ref_sample[31]}}, ref_sample} + {scaled[33], scaled};
        descend_next = desc_arm || (desc_sum < $signed({{3{held_ref[31]}}, held_ref}));

        rise_limit = {{2{last_phase_reg[31]}}, last_phase_reg} + {18'b0, rise_threshold};
        rising     = $signed({{2{phase_sample[31]}}, phase_sample}) > rise_limit;
        if (descend_next && in_window_next && rising)
        begin
            in_window_next = 1'b0;
        end

        if (in_window_next)
        begin
            corrected_phase = phase_sample;
        end
        else if (phase_sample == SAMPLE_MIN)
        begin
            corrected_phase = SAMPLE_MAX;
        end
        else
        begin
            corrected_phase = -phase_sample;
        end
        polarity_negative = !in_window_next;
    end

endmodule

/* hdl/pole_polarity_calibrator.sv */
// ----------------------------------------------------------------------------
// pole_polarity_calibrator
// Tracks reference-voltage peaks over a sample window and corrects phase polarity.
// ----------------------------------------------------------------------------
// Usage:
//   sample_in  - valid/ready, one ref_sample and phase_sample per transaction
//   result_out - valid/ready, one result per input transaction, in order
//   cfg        - valid/ready register writes (index, data), always ready;
//                write only while the block is idle
// Timing: after an input transaction the window ring rotates once around
// plus one step, then the peak test, the descent multiply and the flag
// update follow in that order, and the result is valid once the flag
// update has written the output register. A new item is taken only in
// idle, so each one finishes its flag update before the next is accepted.
// A finished result sits in the output register; the next input is accepted
// meanwhile, and the flag update waits while result_out is stalled.
// Reset clears the window, flags and counters and loads register defaults;
// polarity then reads negative until the trigger arms.
// ----------------------------------------------------------------------------
module pole_polarity_calibrator #(
    parameter int WINDOW_LEN = ppc_pkg::WINDOW_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ppc_in_if.sink     sample_in,
    ppc_out_if.source  result_out,
    ppc_cfg_if.sink    cfg
);
    import ppc_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_PEAK  = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_CALIB = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   walk_cnt_reg, walk_cnt_next;
    logic [CNT_W-1:0]   dec_cnt_reg;
    sample_t            ref_reg, phase_reg;
    sample_t            captured_reg, held_reg, peak_reg, max_reg;
    thresh_t            trig_thr_reg, rise_thr_reg;
    ratio_t             ratio_reg;

    logic               out_valid_reg;
    sample_t            out_corr_reg, out_held_reg, out_max_reg;
    logic               out_neg_reg;

    ppc_win_ctrl_t      win_ctrl;
    ppc_cal_ctrl_t      cal_ctrl;
    sample_t            win_head, win_mid, win_tail;
    sample_t            cal_corr;
    logic               cal_neg;
    logic               in_fire;
    logic               out_free;

    assign sample_in.ready = (state_reg == ST_IDLE);
    assign in_fire         = sample_in.valid && sample_in.ready;
    assign out_free        = !out_valid_reg || result_out.ready;
    assign cfg.ready       = 1'b1;

    always_comb
    begin
        state_next         = state_reg;
        walk_cnt_next      = walk_cnt_reg;
        win_ctrl.shift     = 1'b0;
        win_ctrl.load_tail = 1'b0;
        cal_ctrl.mul_en    = 1'b0;
        cal_ctrl.upd_en    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                walk_cnt_next = '0;
                if (in_fire)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                win_ctrl.shift = 1'b1;
                walk_cnt_next  = walk_cnt_reg + 1'b1;
                if (walk_cnt_reg == CNT_W'(WINDOW_LEN))
                begin
                    win_ctrl.load_tail = 1'b1;
                    state_next         = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cal_ctrl.mul_en = 1'b1;
                state_next      = ST_CALIB;
            end
            ST_CALIB:
            begin
                if (out_free)
                begin
                    cal_ctrl.upd_en = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_cnt_reg  <= '0;
            dec_cnt_reg   <= '0;
            captured_reg  <= '0;
            held_reg      <= '0;
            peak_reg      <= '0;
            trig_thr_reg  <= TRIGGER_THRESHOLD_RST;
            rise_thr_reg  <= RISE_THRESHOLD_RST;
            ratio_reg     <= FALL_RATIO_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_cnt_reg <= walk_cnt_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_TRIGGER_THRESHOLD: trig_thr_reg <= cfg.data[15:0];
                    REG_RISE_THRESHOLD:    rise_thr_reg <= cfg.data[15:0];
                    REG_FALL_RATIO:        ratio_reg    <= cfg.data;
                    default:               ;
                endcase
            end

            // decimated hold, every WINDOW_LEN+1 transactions
            if (in_fire)
            begin
                if (dec_cnt_reg < CNT_W'(WINDOW_LEN))
                begin
                    dec_cnt_reg <= dec_cnt_reg + 1'b1;
                end
                else
                begin
                    dec_cnt_reg  <= '0;
                    held_reg     <= captured_reg;
                    captured_reg <= sample_in.ref_sample;
                end
            end

            if (state_reg == ST_PEAK && win_tail > win_head && win_mid > win_tail)
            begin
                peak_reg <= max_reg;
            end

            if (cal_ctrl.upd_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ref_reg   <= sample_in.ref_sample;
            phase_reg <= sample_in.phase_sample;
            max_reg   <= MAX_SEED;
        end
        else if (state_reg == ST_WALK && walk_cnt_reg <= CNT_W'(WINDOW_LEN - 2)
                 && win_head > max_reg)
        begin
            // the head cell shows the k-th oldest sample on walk step k
            max_reg <= win_head;
        end

        if (cal_ctrl.upd_en)
        begin
            out_corr_reg <= cal_corr;
            out_neg_reg  <= cal_neg;
            out_held_reg <= held_reg;
            out_max_reg  <= peak_reg;
        end
    end

    ppc_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win_ctrl),
        .new_sample (ref_reg),
        .head       (win_head),
        .mid        (win_mid),
        .tail       (win_tail)
    );

    ppc_calib u_calib (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (cal_ctrl),
        .trigger_threshold (trig_thr_reg),
        .rise_threshold    (rise_thr_reg),
        .fall_ratio        (ratio_reg),
        .ref_sample        (ref_reg),
        .phase_sample      (phase_reg),
        .held_ref          (held_reg),
        .peak_value        (peak_reg),
        .corrected_phase   (cal_corr),
        .polarity_negative (cal_neg)
    );

    assign result_out.valid             = out_valid_reg;
    assign result_out.corrected_phase   = out_corr_reg;
    assign result_out.polarity_negative = out_neg_reg;
    assign result_out.held_value        = out_held_reg;
    assign result_out.local_max         = out_max_reg;

`ifndef SYNTHESIS
    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_WALK)
        else $error("accepted transaction did not start the window walk");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> walk_cnt_reg <= CNT_W'(WINDOW_LEN))
        else $error("walk counter ran past the window");

    a_dec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dec_cnt_reg <= CNT_W'(WINDOW_LEN))
        else $error("decimation counter out of range");

    a_out_from_calib: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_CALIB))
        else $error("result raised outside the flag update");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cal_ctrl.upd_en |-> (!out_valid_reg || result_out.ready))
        else $error("pending result overwritten");
`endif

endmodule
